// ===== design/wpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes of the wrapping position extender.
// Depends on nothing; every other design file imports it.
package wpe_pkg;

   localparam int POS_BITS_DEF = 27;
   localparam int WRAP_W = 32;
   localparam int BPS_W = 24;
   localparam int BPF_W = 7;
   localparam int DIV_W = 17;
   localparam int FRAMES_W = 63;
   localparam int MS_PER_SEC = 1000;
   localparam int RAW_W = 32;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 1;

   localparam logic [BPS_W-1:0] BPS_RESET = BPS_W'(176400);
   localparam logic [BPF_W-1:0] BPF_RESET = BPF_W'(4);
   localparam logic [FRAMES_W-1:0] FRAMES_MAX = {FRAMES_W{1'b1}};

   localparam logic [CSR_ADDR_W-1:0] CSR_BPS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BPF = 1'b1;

   typedef enum logic {
      OP_REPORT,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      UNIT_MS,
      UNIT_BYTES,
      UNIT_SAMPLES,
      UNIT_FAILED
   } unit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic       update;
      logic       clear;
      logic [1:0] unit;
   } trk_cmd_type;

   typedef struct packed {
      logic held;
      logic wrapped;
   } trk_flags_type;

   typedef struct packed {
      logic load;
      logic load_ms;
      logic mul_step;
      logic div_step;
   } md_ctrl_type;

endpackage

// ===== design/wpe_tracker.sv =====
`timescale 1ns / 1ps
// Position history: last unit, last position, wrap count; backward-jump hold
// and wrap detection. Depends on wpe_pkg.
module wpe_tracker #(
   parameter int POS_BITS = wpe_pkg::POS_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wpe_pkg::trk_cmd_type                   cmd,
   input  logic [wpe_pkg::RAW_W-1:0]              raw_position,
   output logic [wpe_pkg::WRAP_W+POS_BITS-1:0]    pos,
   output wpe_pkg::trk_flags_type                 flags
);
   import wpe_pkg::*;

   logic                  valid_ff, valid_in;
   logic [1:0]            unit_ff, unit_in;
   logic [POS_BITS-1:0]   last_ff, last_in;
   logic [WRAP_W-1:0]     wrap_ff, wrap_in;

   logic [POS_BITS-1:0]   cur;
   logic [POS_BITS-1:0]   diff;
   logic [POS_BITS-1:0]   cur_sel;
   logic                  first;
   logic                  back;
   logic                  wrap;

   always_comb begin
      cur     = raw_position[POS_BITS-1:0];
      diff    = cur - last_ff;
      back    = diff[POS_BITS-1];
      first   = !valid_ff || (cmd.unit != unit_ff);
      cur_sel = (!first && back) ? last_ff : cur;
      wrap    = !first && last_ff[POS_BITS-1] && !cur_sel[POS_BITS-1];
      flags.held    = !first && back;
      flags.wrapped = wrap;
      if (first) begin
         wrap_in = '0;
      end else if (wrap && (wrap_ff != {WRAP_W{1'b1}})) begin
         wrap_in = wrap_ff + WRAP_W'(1);
      end else begin
         wrap_in = wrap_ff;
      end
      pos = {wrap_in, cur_sel};

      valid_in = valid_ff;
      unit_in  = unit_ff;
      last_in  = last_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
         last_in  = '0;
         wrap_in  = '0;
      end else if (cmd.update) begin
         valid_in = 1'b1;
         unit_in  = cmd.unit;
         last_in  = cur_sel;
      end else begin
         wrap_in  = wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         unit_ff  <= '0;
         last_ff  <= '0;
         wrap_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         unit_ff  <= unit_in;
         last_ff  <= last_in;
         wrap_ff  <= wrap_in;
      end
   end

endmodule

// ===== design/wpe_muldiv.sv =====
`timescale 1ns / 1ps
// Shared shift-add multiplier and restoring divider on one work register.
// Depends on wpe_pkg; sequenced by the top level.
module wpe_muldiv #(
   parameter int POS_BITS = wpe_pkg::POS_BITS_DEF
) (
   input  logic                                   clock,
   input  wpe_pkg::md_ctrl_type                   ctrl,
   input  logic [wpe_pkg::WRAP_W+POS_BITS-1:0]    pos,
   input  logic [wpe_pkg::BPS_W-1:0]              bytes_per_second,
   input  logic [wpe_pkg::BPF_W-1:0]              bytes_per_frame,
   output logic [wpe_pkg::FRAMES_W-1:0]           frames
);
   import wpe_pkg::*;

   localparam int POS_W  = WRAP_W + POS_BITS;
   localparam int PROD_W = POS_W + BPS_W;

   logic [PROD_W-1:0] work_ff, work_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;

   logic [BPF_W-1:0]  bpf_eff;
   logic [POS_W:0]    sum;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              ge;

   always_comb begin
      bpf_eff = (bytes_per_frame == '0) ? BPF_W'(1) : bytes_per_frame;
      sum     = {1'b0, work_ff[PROD_W-1:BPS_W]} + {1'b0, pos_ff};
      trial   = {rem_ff, work_ff[PROD_W-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = trial >= {1'b0, div_ff};

      work_in = work_ff;
      pos_in  = pos_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (ctrl.load) begin
         pos_in = pos;
         rem_in = '0;
         if (ctrl.load_ms) begin
            work_in = {{POS_W{1'b0}}, bytes_per_second};
            div_in  = DIV_W'(bpf_eff) * DIV_W'(MS_PER_SEC);
         end else begin
            work_in = {{BPS_W{1'b0}}, pos};
            div_in  = DIV_W'(bpf_eff);
         end
      end else if (ctrl.mul_step) begin
         if (work_ff[0]) begin
            work_in = {sum, work_ff[BPS_W-1:1]};
         end else begin
            work_in = {1'b0, work_ff[PROD_W-1:1]};
         end
      end else if (ctrl.div_step) begin
         work_in = {work_ff[PROD_W-2:0], ge};
         rem_in  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      end

      frames = (|work_ff[PROD_W-1:FRAMES_W]) ? FRAMES_MAX : work_ff[FRAMES_W-1:0];
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      pos_ff  <= pos_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

endmodule

// ===== design/wrapping_position_extender.sv =====
`timescale 1ns / 1ps
// Wrapping position extender: turns raw device position reports into a
// monotonic frame position. Depends on wpe_pkg, wpe_tracker and wpe_muldiv.
//
// One transaction is handled at a time; req_tready is high only while the
// sequencer is idle. For a millisecond report the shared work register first
// runs a shift-add multiply by bytes_per_second, one multiplier bit per cycle,
// then a restoring divide by 1000 * bytes_per_frame, one quotient bit per
// cycle. A byte report runs the divide only. A sample report and a failed
// report go straight to the done state; a clear is handled in the idle state.
// The finished result sits in an output register, so the next transaction is
// accepted while it waits for rsp_tready. Configuration registers are
// sampled at the start of each report.
module wrapping_position_extender #(
   parameter int POS_BITS = wpe_pkg::POS_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: raw_position[31:0]
   input  logic [wpe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: op[0], time_unit[2:1]
   input  logic [wpe_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: frames[62:0], held[63], wrapped[64], zero fill[71:65]
   output logic [wpe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [wpe_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [wpe_pkg::BPS_W-1:0]          csr_wdata
);
   import wpe_pkg::*;

   localparam int POS_W  = WRAP_W + POS_BITS;
   localparam int PROD_W = POS_W + BPS_W;
   localparam int CNT_W  = $clog2(PROD_W);

   fsm_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BPS_W-1:0]   bps_ff, bps_in;
   logic [BPF_W-1:0]   bpf_ff, bpf_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   trk_flags_type      flags_ff, flags_in;
   logic               zero_ff, zero_in;

   logic               req_take;
   op_type             req_op;
   unit_type           req_unit;
   logic               out_free;
   trk_cmd_type        trk_cmd;
   trk_flags_type      trk_flags;
   logic [POS_W-1:0]   trk_pos;
   md_ctrl_type        md_ctrl;
   logic [FRAMES_W-1:0] md_frames;

   assign req_op   = op_type'(req_tuser[0]);
   assign req_unit = unit_type'(req_tuser[2:1]);
   assign req_take = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   wpe_tracker #(
      .POS_BITS(POS_BITS)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .cmd          (trk_cmd),
      .raw_position (req_tdata[RAW_W-1:0]),
      .pos          (trk_pos),
      .flags        (trk_flags)
   );

   wpe_muldiv #(
      .POS_BITS(POS_BITS)
   ) u_muldiv (
      .clock            (clock),
      .ctrl             (md_ctrl),
      .pos              (trk_pos),
      .bytes_per_second (bps_ff),
      .bytes_per_frame  (bpf_ff),
      .frames           (md_frames)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_op == OP_REPORT)) begin
               case (req_unit)
                  UNIT_MS:    state_in = ST_MUL;
                  UNIT_BYTES: state_in = ST_DIV;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL: begin
            if (cnt_ff == CNT_W'(BPS_W - 1)) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      trk_cmd       = '0;
      trk_cmd.unit  = req_unit;
      md_ctrl       = '0;
      cnt_in        = cnt_ff;
      flags_in      = flags_ff;
      zero_in       = zero_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      bps_in        = bps_ff;
      bpf_in        = bpf_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_BPS: bps_in = csr_wdata;
            CSR_BPF: bpf_in = csr_wdata[BPF_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_take) begin
               trk_cmd.clear  = (req_op == OP_CLEAR);
               trk_cmd.update = (req_op == OP_REPORT) && (req_unit != UNIT_FAILED);
               md_ctrl.load    = trk_cmd.update;
               md_ctrl.load_ms = (req_unit == UNIT_MS);
               zero_in         = (req_unit == UNIT_FAILED);
               flags_in        = trk_cmd.update ? trk_flags : '0;
            end
         end
         ST_MUL: begin
            md_ctrl.mul_step = 1'b1;
            cnt_in = (cnt_ff == CNT_W'(BPS_W - 1)) ? '0 : cnt_ff + CNT_W'(1);
         end
         ST_DIV: begin
            md_ctrl.div_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {(RSP_DATA_W - FRAMES_W - 2)'(0), flags_ff.wrapped,
                                flags_ff.held, zero_ff ? {FRAMES_W{1'b0}} : md_frames};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         bps_ff        <= BPS_RESET;
         bpf_ff        <= BPF_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         bps_ff        <= bps_in;
         bpf_ff        <= bpf_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      flags_ff     <= flags_in;
      zero_ff      <= zero_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_op == OP_CLEAR)) |=> (state_ff == ST_IDLE))
      else $error("clear transaction left the idle state");

   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_op == OP_REPORT) && (req_unit == UNIT_MS)) |=> (state_ff == ST_MUL))
      else $error("millisecond report did not start the multiply");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff < CNT_W'(BPS_W)))
      else $error("multiply step count out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_tdata_ff[FRAMES_W] && rsp_tdata_ff[FRAMES_W+1]))
      else $error("held and wrapped both set");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff != ST_DONE) && $past(state_ff != ST_DONE) && !reset && !$past(reset))
      |-> !$rose(rsp_tvalid_ff))
      else $error("result loaded outside the done state");

endmodule
